[design/modq_pkg.sv]
// shared types, constants and helper functions for the q = 7681 arithmetic unit
package modq_pkg;

    localparam logic [31:0] Q          = 32'd7681;
    localparam logic [15:0] QINV16     = 16'hE201;
    localparam logic [31:0] QINV32     = 32'h8B83E201;
    localparam logic [31:0] ALPHA_OFS  = 32'd4;
    localparam logic [12:0] LOW13      = 13'h1FFF;
    localparam int          FOLD_SHIFT = 13;
    localparam int          INV_STEPS  = 12;
    localparam int          INV_SKIP   = 9;
    localparam int          LANE_DEPTH = 3;
    localparam int          LEVELS     = INV_STEPS + 1;
    localparam int          STAGES     = LEVELS * LANE_DEPTH;

    typedef enum logic [3:0] {
        ACT_MONT_RED   = 4'd0,
        ACT_PLANT_RED  = 4'd1,
        ACT_FOLD13     = 4'd2,
        ACT_CSUBQ      = 4'd3,
        ACT_MONT_MUL   = 4'd4,
        ACT_PLANT_MUL  = 4'd5,
        ACT_PLANT_CONST = 4'd6,
        ACT_MONT_INV   = 4'd7,
        ACT_PLANT_INV  = 4'd8
    } action_t;

    typedef enum logic [3:0] {
        OP_MONT_MUL,
        OP_PLANT_MUL,
        OP_MONT_RED,
        OP_PLANT_RED,
        OP_PLANT_CONST,
        OP_FOLD,
        OP_CSUBQ,
        OP_PASS,
        OP_ZERO
    } lane_op_t;

    // 2^13 counted as 2^9 - 1
    function automatic logic [15:0] fold13(input logic [15:0] a);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = {3'b000, a[12:0] & LOW13};
        hi = {{FOLD_SHIFT{a[15]}}, a[15:FOLD_SHIFT]};
        return lo + (hi << 9) - hi;
    endfunction

    function automatic logic [15:0] csubq(input logic [15:0] a);
        logic signed [16:0] x;
        logic signed [16:0] q17;
        q17 = 17'(Q);
        x = {a[15], a};
        if (x < 0) begin
            x = x + q17;
        end
        x = x - q17;
        if (x < 0) begin
            x = x + q17;
        end
        return x[15:0];
    endfunction

    function automatic lane_op_t action_op(input action_t act);
        lane_op_t op;
        case (act)
            ACT_MONT_RED:    op = OP_MONT_RED;
            ACT_PLANT_RED:   op = OP_PLANT_RED;
            ACT_FOLD13:      op = OP_FOLD;
            ACT_CSUBQ:       op = OP_CSUBQ;
            ACT_MONT_MUL:    op = OP_MONT_MUL;
            ACT_PLANT_MUL:   op = OP_PLANT_MUL;
            ACT_PLANT_CONST: op = OP_PLANT_CONST;
            default:         op = OP_ZERO;
        endcase
        return op;
    endfunction

endpackage

[design/modq_lane.sv]
// three-stage modular multiply / reduce lane (montgomery and plantard) with fold13, csubq and pass ops
module modq_lane (
    input  logic                  aclk,
    input  logic [2:0]            en,
    input  modq_pkg::lane_op_t    op,
    input  logic signed [15:0]    a,
    input  logic signed [31:0]    b,
    output logic signed [15:0]    result
);
    import modq_pkg::*;

    lane_op_t    op_a_reg, op_b_reg;
    logic [31:0] p_a_reg, p_b_reg, w_b_reg;
    logic [15:0] pass_a_reg, pass_b_reg, r_c_reg;

    logic [31:0] p_a_next, w_b_next;
    logic [15:0] pass_a_next, r_c_next;
    logic signed [31:0] mult_b;
    logic signed [47:0] prod;
    logic [31:0] u_full, pq, u_ext, uq, d, h_ext, t;

    // stage a: operand product
    always_comb begin
        if (op == OP_MONT_MUL || op == OP_PLANT_MUL) begin
            mult_b = {{16{b[15]}}, b[15:0]};
        end else begin
            mult_b = b;
        end
        prod = a * mult_b;
        case (op)
            OP_MONT_RED, OP_PLANT_RED:                 p_a_next = b;
            OP_MONT_MUL, OP_PLANT_MUL, OP_PLANT_CONST: p_a_next = prod[31:0];
            default:                                   p_a_next = '0;
        endcase
        case (op)
            OP_FOLD:  pass_a_next = fold13(a);
            OP_CSUBQ: pass_a_next = csubq(a);
            OP_PASS:  pass_a_next = a;
            default:  pass_a_next = '0;
        endcase
    end

    // stage b: multiply by q inverse
    always_comb begin
        u_full = {16'h0000, p_a_reg[15:0]} * {16'h0000, QINV16};
        pq     = p_a_reg * QINV32;
        case (op_a_reg)
            OP_MONT_MUL, OP_MONT_RED:   w_b_next = {16'h0000, u_full[15:0]};
            OP_PLANT_MUL, OP_PLANT_RED: w_b_next = pq;
            OP_PLANT_CONST:             w_b_next = p_a_reg;
            default:                    w_b_next = '0;
        endcase
    end

    // stage c: multiply by q and keep the high half
    always_comb begin
        u_ext = {{16{w_b_reg[15]}}, w_b_reg[15:0]};
        uq    = u_ext * Q;
        d     = p_b_reg - uq;
        h_ext = {{16{w_b_reg[31]}}, w_b_reg[31:16]} + ALPHA_OFS;
        t     = h_ext * Q;
        case (op_b_reg)
            OP_MONT_MUL, OP_MONT_RED:                  r_c_next = d[31:16];
            OP_PLANT_MUL, OP_PLANT_RED, OP_PLANT_CONST: r_c_next = t[31:16];
            OP_FOLD, OP_CSUBQ, OP_PASS:                r_c_next = pass_b_reg;
            default:                                   r_c_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            op_a_reg   <= op;
            p_a_reg    <= p_a_next;
            pass_a_reg <= pass_a_next;
        end
        if (en[1]) begin
            op_b_reg   <= op_a_reg;
            p_b_reg    <= p_a_reg;
            w_b_reg    <= w_b_next;
            pass_b_reg <= pass_a_reg;
        end
        if (en[2]) begin
            r_c_reg <= r_c_next;
        end
    end

    assign result = r_c_reg;

endmodule

[design/modq_arith_unit.sv]
// top level: pipelined modular arithmetic unit for q = 7681
// Usage: present action, a_operand and b_operand on the s_ channel with
// s_valid; a word is taken when s_valid and s_ready are both high. Each
// word yields exactly one signed 16-bit m_result on the m_ channel, in
// order, taken when m_valid and m_ready are both high.
// Every action passes 13 levels of 3-stage modular multiply lanes.
// Throughput is one word per cycle while m_ready is high. The inversion
// chain runs a squaring lane and an accumulating lane side by side at
// each level; other actions finish in the first level and ride along.
// Each stage holds its word while the next stage is full and stalled, so
// a stalled receiver fills empty stages first and s_ready drops only when
// every stage holds a word. Reset clears all stage valid bits; no words
// are in flight afterward and s_ready is high.
module modq_arith_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_action,
    input  logic signed [15:0]   s_a_operand,
    input  logic signed [31:0]   s_b_operand,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_result
);
    import modq_pkg::*;

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   en;
    action_t           act_reg [STAGES];

    logic signed [15:0] sq_out [LEVELS];
    logic signed [15:0] t_out  [LEVELS];

    assign en[STAGES] = m_ready;

    genvar s, l;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            assign en[s] = !v_reg[s] || en[s+1];
            if (s == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        v_reg[s] <= 1'b0;
                    end else if (en[s]) begin
                        v_reg[s] <= s_valid;
                    end
                end
                always_ff @(posedge aclk) begin
                    if (en[s]) begin
                        act_reg[s] <= action_t'(s_action);
                    end
                end
            end else begin : g_rest
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        v_reg[s] <= 1'b0;
                    end else if (en[s]) begin
                        v_reg[s] <= v_reg[s-1];
                    end
                end
                always_ff @(posedge aclk) begin
                    if (en[s]) begin
                        act_reg[s] <= act_reg[s-1];
                    end
                end
            end
        end

        for (l = 0; l < LEVELS; l++) begin : g_level
            action_t            act_in;
            logic               inv;
            lane_op_t           dom_op, sq_op, t_op;
            logic signed [15:0] a_in, t_a;
            logic signed [31:0] sq_b, t_b;

            if (l == 0) begin : g_in0
                assign act_in = action_t'(s_action);
                assign a_in   = s_a_operand;
                assign t_a    = s_a_operand;
                assign t_b    = s_b_operand;
            end else begin : g_inn
                assign act_in = act_reg[l*LANE_DEPTH-1];
                assign a_in   = sq_out[l-1];
                assign t_a    = t_out[l-1];
                assign t_b    = {{16{sq_out[l-1][15]}}, sq_out[l-1]};
            end

            assign sq_b = {{16{a_in[15]}}, a_in};

            always_comb begin
                inv    = (act_in == ACT_MONT_INV) || (act_in == ACT_PLANT_INV);
                dom_op = (act_in == ACT_PLANT_INV) ? OP_PLANT_MUL : OP_MONT_MUL;
                sq_op  = dom_op;
                if (l == 0) begin
                    // running product starts as the operand itself
                    t_op = inv ? OP_PASS : action_op(act_in);
                end else if (inv && l != INV_SKIP) begin
                    t_op = dom_op;
                end else begin
                    t_op = OP_PASS;
                end
            end

            modq_lane u_t_lane (
                .aclk   (aclk),
                .en     (en[l*LANE_DEPTH +: LANE_DEPTH]),
                .op     (t_op),
                .a      (t_a),
                .b      (t_b),
                .result (t_out[l])
            );

            modq_lane u_sq_lane (
                .aclk   (aclk),
                .en     (en[l*LANE_DEPTH +: LANE_DEPTH]),
                .op     (sq_op),
                .a      (a_in),
                .b      (sq_b),
                .result (sq_out[l])
            );
        end
    endgenerate

    assign s_ready  = en[0];
    assign m_valid  = v_reg[STAGES-1];
    assign m_result = t_out[LEVELS-1];

endmodule

[tb/sv/testbench.sv]
// testbench for the q = 7681 modular arithmetic unit: directed and random words, scoreboard check
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import modq_pkg::*;

    localparam int Q_INT = 7681;
    localparam int CYCLE_LIMIT = 400000;

    // expected results in order
    class modq_scoreboard;
        logic [15:0] pending[$];
        int mismatches;
        int checked;

        function new();
            mismatches = 0;
            checked = 0;
        endfunction

        function void note_word(input logic [15:0] want);
            pending.push_back(want);
        endfunction

        function void check_result(input logic [15:0] got);
            logic [15:0] want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [3:0] s_action;
    logic signed [15:0] s_a_operand;
    logic signed [31:0] s_b_operand;
    logic m_valid;
    logic m_ready;
    logic signed [15:0] m_result;

    modq_scoreboard sb;
    int cycles;
    bit no_idle;
    bit hold_off;

    modq_arith_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_a_operand(s_a_operand), .s_b_operand(s_b_operand),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result)
    );

    function automatic logic signed [15:0] to16(input longint v);
        logic [15:0] w;
        w = v[15:0];
        return $signed(w);
    endfunction

    function automatic int mont_reduce(input longint x);
        longint u;
        longint d;
        u = to16(x * 64'hE201);
        d = x - u * Q_INT;
        return to16(d >>> 16);
    endfunction

    function automatic int plant_finish(input logic [31:0] p);
        longint h;
        h = $signed(p[31:16]);
        return to16(((h + 4) * Q_INT) >>> 16);
    endfunction

    function automatic int plant_reduce(input longint x);
        logic [63:0] p;
        p = x * 64'h8B83E201;
        return plant_finish(p[31:0]);
    endfunction

    function automatic int inverse_of(input int a, input bit plant);
        int pw;
        int acc;
        pw = a;
        acc = a;
        for (int i = 1; i <= INV_STEPS; i++) begin
            pw = plant ? plant_reduce(longint'(pw) * pw) : mont_reduce(longint'(pw) * pw);
            if (i != INV_SKIP)
                acc = plant ? plant_reduce(longint'(acc) * pw) : mont_reduce(longint'(acc) * pw);
        end
        return acc;
    endfunction

    function automatic logic [15:0] modq_result(input logic [3:0] act,
                                               input logic signed [15:0] a,
                                               input logic signed [31:0] b);
        int r;
        int ai;
        longint bl;
        longint b16;
        longint hi;
        logic [63:0] prod;
        ai = a;
        bl = b;
        b16 = $signed(b[15:0]);
        case (act)
            ACT_MONT_RED:    r = mont_reduce(bl);
            ACT_PLANT_RED:   r = plant_reduce(bl);
            ACT_FOLD13: begin
                hi = ai >>> 13;
                r = to16((ai & 32'h1FFF) + hi * 512 - hi);
            end
            ACT_CSUBQ: begin
                r = ai;
                if (r < 0) r += Q_INT;
                r -= Q_INT;
                if (r < 0) r += Q_INT;
            end
            ACT_MONT_MUL:    r = mont_reduce(ai * b16);
            ACT_PLANT_MUL:   r = plant_reduce(ai * b16);
            ACT_PLANT_CONST: begin
                prod = longint'(ai) * bl;
                r = plant_finish(prod[31:0]);
            end
            ACT_MONT_INV:    r = inverse_of(ai, 1'b0);
            ACT_PLANT_INV:   r = inverse_of(ai, 1'b1);
            default:         r = 0;
        endcase
        return r[15:0];
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        int burst;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result(m_result);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (burst) begin
                    @(posedge aclk);
                end
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [3:0] act, input logic [15:0] a,
                             input logic [31:0] b);
        if (!no_idle && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_a_operand <= a;
        s_b_operand <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(modq_result(act, a, b));
    endtask

    task automatic send_random(input int count);
        logic [3:0] act;
        logic [31:0] b;
        for (int i = 0; i < count; i++) begin
            act = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            b = $urandom();
            if ($urandom_range(0, 3) == 0)
                b = $signed(16'($urandom()));
            send_word(act, 16'($urandom()), b);
        end
    endtask

    initial begin
        action_t acts[9];
        int waited;
        sb = new();
        no_idle = 1'b0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = '0;
        s_a_operand = '0;
        s_b_operand = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        acts = '{ACT_MONT_RED, ACT_PLANT_RED, ACT_FOLD13, ACT_CSUBQ, ACT_MONT_MUL,
                  ACT_PLANT_MUL, ACT_PLANT_CONST, ACT_MONT_INV, ACT_PLANT_INV};
        // extremes of every action
        foreach (acts[k]) begin
            send_word(acts[k], 16'h7FFF, 32'h8000_0000);
            send_word(acts[k], 16'h8000, 32'h7FFF_FFFF);
        end
        send_word(ACT_CSUBQ, 16'(Q_INT), 32'd0);
        send_word(ACT_CSUBQ, 16'(-Q_INT), 32'd0);
        send_word(ACT_FOLD13, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(ACT_MONT_INV, 16'd0, 32'd0);
        send_word(4'd15, 16'h1234, 32'h5678);

        send_random(300);

        // long receiver hold-off while the sender keeps offering words
        fork
            begin
                hold_off = 1'b1;
                repeat (150) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(120);
        join

        send_random(430);
        no_idle = 1'b1;
        send_random(150);
        s_valid <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
design/modq_pkg.sv
design/modq_lane.sv
design/modq_arith_unit.sv
tb/sv/testbench.sv
